// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/scc_pkg.sv =====
`timescale 1ns / 1ps
package scc_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned TailLimit  = 56;
  localparam logic [7:0]  PadMark    = 8'h80;
  localparam int unsigned BufAw      = 6;
  localparam int unsigned StAw       = 2;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // request from the control sequencer to the compression engine
  typedef struct packed {
    logic       start;
    logic       use_buf;   // message bytes come from the block buffer
    logic       fin;       // final padded block
    logic       tail_hi;   // tail of 56 or more
    logic       len_blk;   // length-only block after a long tail
    logic [5:0] tail;
    logic [31:0] a_num;
  } scc_req_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by round i
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] init_word(input logic [1:0] k);
    logic [31:0] v;
    case (k)
      2'd0: v = InitA;
      2'd1: v = InitB;
      2'd2: v = InitC;
      default: v = InitD;
    endcase
    return v;
  endfunction
endpackage

// ===== rtl/core/scc_ram.sv =====
`timescale 1ns / 1ps
module scc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/scc_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// MD5 compression: a fetch pass gathers the 64 block bytes into 16 message words, then the
// four state words are read, 64 rounds run one per cycle and the state words are added back.
module scc_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scc_pkg::scc_req_t             req,
  output logic                          busy,
  output logic                          done,
  output logic [scc_pkg::BufAw-1:0]     buf_raddr,
  input  logic [7:0]                    buf_rdata,
  input  logic                          hold_out,
  output logic                          st_rst,
  output logic [scc_pkg::StAw-1:0]      st_raddr,
  input  logic [31:0]                   st_rdata,
  output logic                          st_we,
  output logic [scc_pkg::StAw-1:0]      st_waddr,
  output logic [31:0]                   st_wdata
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  scc_pkg::scc_req_t req_r;
  logic [31:0] mw_r [16];
  logic [31:0] a_r, b_r, c_r, d_r;
  logic        ld_v_r;
  logic [5:0]  ld_pos_r;
  logic [7:0]  byte_v;
  logic [5:0]  fpos;
  logic [31:0] f, sum, rot, bn, init_v;
  logic [5:0]  ri;

  assign busy = (state_r != S_IDLE);
  assign ri = cnt_r[5:0];
  // short-tail final block: message bytes sit four places behind the buffer address
  assign buf_raddr = (req_r.fin && !req_r.tail_hi) ? 6'(cnt_r[5:0] - 6'd4) : cnt_r[5:0];
  assign st_raddr = cnt_r[1:0];
  assign st_rst = 1'b0;

  // byte of the block being compressed at position ld_pos_r
  always_comb begin
    fpos = 6'(ld_pos_r - 6'd4);
    byte_v = 8'h00;
    if (!req_r.fin) begin
      byte_v = buf_rdata;
    end else if (req_r.len_blk) begin
      if (ld_pos_r < 6'd4) byte_v = req_r.a_num[ld_pos_r[1:0]*8 +: 8];
    end else if (req_r.tail_hi) begin
      if (ld_pos_r < req_r.tail) byte_v = buf_rdata;
      else if (ld_pos_r == req_r.tail) byte_v = scc_pkg::PadMark;
    end else begin
      if (ld_pos_r < 6'd4) byte_v = req_r.a_num[ld_pos_r[1:0]*8 +: 8];
      else if (fpos < req_r.tail) byte_v = buf_rdata;
      else if (fpos == req_r.tail) byte_v = scc_pkg::PadMark;
    end
    bn = (req_r.a_num >> 2) | 32'd1;
    if (req_r.fin && !(req_r.tail_hi && !req_r.len_blk) && ld_pos_r >= 6'd60) begin
      byte_v = bn[ld_pos_r[1:0]*8 +: 8];
    end
  end

  always_comb begin
    case (ri[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (d_r & b_r) | (~d_r & c_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    sum = a_r + f + scc_pkg::round_k(ri) + mw_r[scc_pkg::round_g(ri)];
    rot = (sum << scc_pkg::round_s(ri)) | (sum >> (6'd32 - {1'b0, scc_pkg::round_s(ri)}));
    init_v = st_rdata;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    done = 1'b0;
    st_we = 1'b0;
    st_waddr = 2'd0;
    st_wdata = 32'd0;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          state_nxt = S_LOAD;
          cnt_nxt = 7'd0;
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd64) begin
          state_nxt = S_INIT;
          cnt_nxt = 7'd0;
        end
      end
      S_INIT: begin
        // read the four state words; each is captured in the cycle after its address is set
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd4) begin
          state_nxt = S_RND;
          cnt_nxt = 7'd0;
        end
      end
      S_RND: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          state_nxt = S_ADD;
          cnt_nxt = 7'd0;
        end
      end
      S_ADD: begin
        if (!hold_out) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r >= 7'd1) begin
            st_we = 1'b1;
            st_waddr = 2'(cnt_r - 7'd1);
            case (st_waddr)
              2'd0: st_wdata = st_rdata + a_r;
              2'd1: st_wdata = st_rdata + b_r;
              2'd2: st_wdata = st_rdata + c_r;
              default: st_wdata = st_rdata + d_r;
            endcase
          end
          if (cnt_r == 7'd4) begin
            state_nxt = S_IDLE;
            done = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= 7'd0;
      ld_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ld_v_r <= (state_r == S_LOAD) && (cnt_r < 7'd64);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.start) begin
      req_r <= req;
    end
    ld_pos_r <= cnt_r[5:0];
    if (ld_v_r) begin
      mw_r[ld_pos_r[5:2]][ld_pos_r[1:0]*8 +: 8] <= byte_v;
    end
    if (state_r == S_INIT && cnt_r >= 7'd1) begin
      case (2'(cnt_r - 7'd1))
        2'd0: a_r <= init_v;
        2'd1: b_r <= init_v;
        2'd2: c_r <= init_v;
        default: d_r <= init_v;
      endcase
    end else if (state_r == S_RND) begin
      a_r <= d_r;
      d_r <= c_r;
      c_r <= b_r;
      b_r <= b_r + rot;
    end
  end

  `ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
  `ASSERT_IMPL(a_we_add, clk, rst_n, st_we, state_r == S_ADD)
  `ASSERT_IMPL(a_start_idle, clk, rst_n, state_r == S_LOAD && cnt_r == 7'd0, req_r.start)
endmodule

// ===== rtl/core/shader_container_checksum.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A byte that completes a block stalls input for one compression (start, fetch, state read,
// rounds, state add); the last byte stalls it until its digest has been taken.
// The last byte runs one or two compressions; the first digest word is offered after them,
// and words A..D follow in order, each once the one before is taken, set by the registered
// state reads. The shared round unit sets the throughput.
// Reset (rst_n low, synchronous): clears control; the hash state then reloads in C_INIT.
module shader_container_checksum (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] message_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [33:32] word_index, zero pad
  output logic        out_tlast   // final_word
);
  localparam logic [2:0] C_INIT = 3'd0;
  localparam logic [2:0] C_RUN  = 3'd1;
  localparam logic [2:0] C_BLK  = 3'd2;
  localparam logic [2:0] C_FIN1 = 3'd3;
  localparam logic [2:0] C_FIN2 = 3'd4;
  localparam logic [2:0] C_OUT  = 3'd5;

  logic [2:0]  cst_r, cst_nxt;
  logic [31:0] cnt_r;
  logic [31:0] cnt_inc;
  logic [1:0]  ow_r;
  logic        orv_r;
  logic [1:0]  ii_r;
  logic        go_r;
  logic        go_fin_r;
  logic        tail_hi_r;
  logic        done, busy, acc;
  scc_pkg::scc_req_t req;
  logic [5:0]  buf_raddr;
  logic [7:0]  buf_rdata;
  logic        st_rst;
  logic [1:0]  st_raddr, e_waddr, s_waddr, s_raddr;
  logic [31:0] st_rdata, e_wdata, s_wdata;
  logic        e_we, s_we;

  assign cnt_inc = cnt_r + 32'd1;
  assign in_tready = (cst_r == C_RUN) && !busy;
  assign acc = in_tvalid && in_tready;

  scc_ram #(.Width(8), .Depth(scc_pkg::BlockBytes)) u_buf (
    .clk(clk), .we(acc), .waddr(cnt_r[5:0]), .wdata(in_tdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );

  always_comb begin
    s_we = e_we;
    s_waddr = e_waddr;
    s_wdata = e_wdata;
    s_raddr = st_raddr;
    if (cst_r == C_INIT) begin
      s_we = 1'b1;
      s_waddr = ii_r;
      s_wdata = scc_pkg::init_word(ii_r);
    end else if (cst_r == C_OUT) begin
      s_raddr = ow_r;
    end
  end

  scc_ram #(.Width(32), .Depth(4)) u_st (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(st_rdata)
  );

  always_comb begin
    req = '0;
    req.start = go_r;
    req.use_buf = 1'b1;
    req.tail = cnt_r[5:0];
    req.a_num = {cnt_r[28:0], 3'b000};
    req.tail_hi = tail_hi_r;
    req.fin = (cst_r == C_FIN1) || (cst_r == C_FIN2);
    req.len_blk = (cst_r == C_FIN2);
  end

  scc_engine u_eng (
    .clk(clk), .rst_n(rst_n), .req(req), .busy(busy), .done(done),
    .buf_raddr(buf_raddr), .buf_rdata(buf_rdata), .hold_out(1'b0),
    .st_rst(st_rst), .st_raddr(st_raddr), .st_rdata(st_rdata),
    .st_we(e_we), .st_waddr(e_waddr), .st_wdata(e_wdata)
  );

  // the output register is loaded from the registered state read, tracked by rd_pend_r
  logic rd_pend_r;
  logic [1:0] rd_idx_r;

  always_comb begin
    cst_nxt = cst_r;
    unique case (cst_r)
      C_INIT: if (ii_r == 2'd3) cst_nxt = C_RUN;
      C_RUN: begin
        if (acc) begin
          if (in_tlast) cst_nxt = (cnt_inc[5:0] == 6'd0) ? C_BLK : C_FIN1;
          else if (cnt_inc[5:0] == 6'd0) cst_nxt = C_BLK;
        end
      end
      C_BLK: if (done) cst_nxt = go_fin_r ? C_FIN1 : C_RUN;
      C_FIN1: if (done) cst_nxt = tail_hi_r ? C_FIN2 : C_OUT;
      C_FIN2: if (done) cst_nxt = C_OUT;
      C_OUT: if (orv_r && out_tready && rd_idx_r == 2'd3) cst_nxt = C_INIT;
      default: cst_nxt = C_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r <= C_INIT;
      cnt_r <= 32'd0;
      ii_r <= 2'd0;
      go_r <= 1'b0;
      go_fin_r <= 1'b0;
      tail_hi_r <= 1'b0;
      orv_r <= 1'b0;
      ow_r <= 2'd0;
      rd_pend_r <= 1'b0;
      rd_idx_r <= 2'd0;
    end else begin
      cst_r <= cst_nxt;
      go_r <= 1'b0;
      if (cst_r == C_INIT) begin
        ii_r <= ii_r + 2'd1;
        cnt_r <= 32'd0;
        ow_r <= 2'd0;
      end
      if (acc) begin
        cnt_r <= cnt_inc;
        go_fin_r <= in_tlast;
        tail_hi_r <= (cnt_inc[5:0] >= 6'(scc_pkg::TailLimit));
        if (in_tlast || cnt_inc[5:0] == 6'd0) go_r <= 1'b1;
      end
      if (done && ((cst_r == C_BLK && go_fin_r) || (cst_r == C_FIN1 && tail_hi_r))) begin
        go_r <= 1'b1;
      end
      // read one state word, then show it until taken
      rd_pend_r <= 1'b0;
      if (cst_r == C_OUT && !orv_r && !rd_pend_r) begin
        rd_pend_r <= 1'b1;
        rd_idx_r <= ow_r;
      end
      if (rd_pend_r) begin
        orv_r <= 1'b1;
        out_tdata <= {6'd0, rd_idx_r, st_rdata};
        out_tlast <= (rd_idx_r == 2'd3);
        ow_r <= ow_r + 2'd1;
      end
      if (orv_r && out_tready) orv_r <= 1'b0;
    end
  end

  assign out_tvalid = orv_r;

  `ASSERT_IMPL(a_no_in_busy, clk, rst_n, in_tready, !busy)
  `ASSERT_IMPL(a_out_phase, clk, rst_n, out_tvalid, cst_r == C_OUT)
  `ASSERT_NEXT(a_last_init, clk, rst_n, out_tvalid && out_tready && out_tlast, cst_r == C_INIT)
endmodule

// ===== tb/tb_shader_container_checksum.sv =====
`timescale 1ns / 1ps
module tb_shader_container_checksum;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        final_word;
  } digest_t;

  localparam int unsigned IdleLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  shader_container_checksum u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // predictor state
  logic [31:0] md_state [4];
  logic [7:0]  msg_block [64];
  logic [31:0] msg_len;
  digest_t     digest_q [$];
  int          fail_cnt;
  int          idle_cycles;
  bit          hold_sink;
  int          burst_left;

  function automatic logic [31:0] rol32(logic [31:0] x, int s);
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic md5_compress(input logic [7:0] blk [64]);
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    int rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] kc [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
      32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
      32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
      32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
      32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
      32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = md_state[0]; b = md_state[1]; c = md_state[2]; d = md_state[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (d & b) | (~d & c); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = d; d = c; c = b;
      b = b + rol32(a + f + kc[i] + m[g], rot[(i / 16) * 4 + (i % 4)]);
      a = t;
    end
    md_state[0] += a; md_state[1] += b; md_state[2] += c; md_state[3] += d;
  endtask

  task automatic rearm_hash();
    md_state[0] = scc_pkg::InitA; md_state[1] = scc_pkg::InitB;
    md_state[2] = scc_pkg::InitC; md_state[3] = scc_pkg::InitD;
    msg_len = '0;
  endtask

  // advance the checksum predictor by one accepted byte
  task automatic predict_checksum(input logic [7:0] data, input logic last);
    logic [7:0]  pad [64];
    logic [31:0] bits_num, mark_num;
    int tail;
    digest_t item;
    msg_block[msg_len[5:0]] = data;
    msg_len++;
    if (msg_len[5:0] == 0) md5_compress(msg_block);
    if (!last) return;
    bits_num = msg_len * 8;
    mark_num = (bits_num >> 2) | 32'd1;
    tail = msg_len[5:0];
    foreach (pad[i]) pad[i] = 8'h00;
    if (tail >= scc_pkg::TailLimit) begin
      for (int i = 0; i < tail; i++) pad[i] = msg_block[i];
      pad[tail] = scc_pkg::PadMark;
      md5_compress(pad);
      foreach (pad[i]) pad[i] = 8'h00;
      for (int i = 0; i < 4; i++) pad[i] = bits_num[8*i +: 8];
    end else begin
      for (int i = 0; i < 4; i++) pad[i] = bits_num[8*i +: 8];
      for (int i = 0; i < tail; i++) pad[4 + i] = msg_block[i];
      pad[4 + tail] = scc_pkg::PadMark;
    end
    for (int i = 0; i < 4; i++) pad[60 + i] = mark_num[8*i +: 8];
    md5_compress(pad);
    for (int k = 0; k < 4; k++) begin
      item.digest_word = md_state[k];
      item.word_index = 2'(k);
      item.final_word = (k == 3);
      digest_q.insert(digest_q.size(), item);
    end
    rearm_hash();
  endtask

  // send one byte; when paced, the sender gaps between random bursts
  task automatic send_byte(input logic [7:0] data, input logic last, input bit paced = 1);
    if (paced) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_checksum(data, last);
  endtask

  task automatic send_message(input int len, input bit paced = 1);
    for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1, paced);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic test_byte_extremes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b0); send_byte(8'haa, 1'b1);
  endtask

  task automatic test_tail_boundaries();
    int lens [6] = '{55, 56, 57, 63, 64, 65};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  task automatic test_sink_backpressure();
    hold_sink = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_sink = 1'b0;
      end
      repeat (6) send_message($urandom_range(1, 8), 0);
    join
    wait_drained();
  endtask

  task automatic test_random_messages();
    int sent;
    sent = 0;
    while (sent < 64) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      send_message(len);
      sent += len;
    end
    wait_drained();
  endtask

  // receiver stalls on its own random pattern unless held off
  always @(posedge clk) begin
    if (!rst_n || hold_sink) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 99) < ((idle_cycles / 64) % 2 ? 100 : 60));
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      digest_t got, want;
      got = '{digest_word: out_tdata[31:0], word_index: out_tdata[33:32],
              final_word: out_tlast};
      if (digest_q.size() == 0) begin
        $error("unexpected digest word %h", got.digest_word);
        fail_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (got.digest_word !== want.digest_word) begin
          $error("digest_word exp %h got %h", want.digest_word, got.digest_word); fail_cnt++;
        end
        if (got.word_index !== want.word_index) begin
          $error("word_index exp %0d got %0d", want.word_index, got.word_index); fail_cnt++;
        end
        if (got.final_word !== want.final_word) begin
          $error("final_word exp %0d got %0d", want.final_word, got.final_word); fail_cnt++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0; out_tready = 1'b0;
    fail_cnt = 0; idle_cycles = 0; hold_sink = 1'b0; burst_left = 0;
    foreach (msg_block[i]) msg_block[i] = 8'h00;
    rearm_hash();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_byte_extremes();
    wait_drained();
    test_tail_boundaries();
    wait_drained();
    test_sink_backpressure();
    test_random_messages();
    if (fail_cnt == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/scc_pkg.sv
rtl/core/scc_ram.sv
rtl/core/scc_engine.sv
rtl/core/shader_container_checksum.sv
tb/tb_shader_container_checksum.sv
